// ----- sv/pip_pkg.sv -----
package pip_pkg;

	localparam int unsigned COORD_BITS       = 16;
	localparam int unsigned DEF_MAX_VERTICES = 256;
	localparam int unsigned MIN_VERTICES     = 3;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_FEW = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t y;
		coord_t x;
	} vertex_t;

endpackage

// ----- sv/pip_in_if.sv -----
interface pip_in_if import pip_pkg::*; ();

	logic       valid;
	logic       ready;
	logic [1:0] operation;
	coord_t     coord_x;
	coord_t     coord_y;

	modport source (output valid, output operation, output coord_x, output coord_y,
		input ready);
	modport sink (input valid, input operation, input coord_x, input coord_y,
		output ready);

endinterface

// ----- sv/pip_out_if.sv -----
interface pip_out_if ();

	logic       valid;
	logic       ready;
	logic       inside_res;
	logic [1:0] status;

	modport source (output valid, output inside_res, output status, input ready);
	modport sink (input valid, input inside_res, input status, output ready);

endinterface

// ----- sv/pip_ram.sv -----
module pip_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/point_in_polygon_test.sv -----
// channel  dir  payload                          transfer when
// req      in   operation, coord_x, coord_y      req.valid && req.ready
// rsp      out  inside_res, status               rsp.valid && rsp.ready
//
// clear, append and unused codes are taken in the idle state and give no result;
// a query on fewer than three vertices goes straight to the output state
// a query walks the edges with one shared 17x17 multiplier, used twice per edge,
// and the vertex store has one read port
// reset empties the polygon through the vertex count; the store is not swept
// the result sits in an output register, so the next item is taken while it waits

module point_in_polygon_test import pip_pkg::*; #(
	parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  logic      clk,
	input  logic      arst_n,
	pip_in_if.sink    req,
	pip_out_if.source rsp
);

	localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
	localparam int unsigned AW = $clog2(MAX_VERTICES);
	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned PW = 2 * DW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIRST,
		S_EA,
		S_EB,
		S_FLUSH,
		S_OUT
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic            ovf_q;
	logic            close_q;
	logic            last_q;
	logic            hit_q;
	logic            par_q;
	logic            pend_q;
	logic            rsp_valid_q;

	vertex_t         first_q;
	vertex_t         a_q;
	vertex_t         b_q;
	coord_t          qx_q;
	coord_t          qy_q;
	logic            few_q;
	logic            strad_q;
	logic            up_q;
	logic signed [PW-1:0] p1_q;
	logic signed [PW-1:0] p2_q;
	logic            rsp_inside_q;
	logic [1:0]      rsp_status_q;

	logic            accept;
	logic            is_query;
	logic            wr_en;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	vertex_t         wr_data;
	vertex_t         rd_data;
	vertex_t         bcur;
	logic            rsp_load;

	logic signed [COORD_BITS-1:0] qx, qy, ax, ay, bx, by;
	logic signed [DW-1:0] ma, mb;
	logic signed [PW-1:0] prod;
	logic            vhit, hhit, strad, up;
	logic            eval, prod_eq, crossed;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_query  = (req.operation == OP_QUERY);

	assign wr_en   = accept && (req.operation == OP_APPEND) && (count_q < CW'(MAX_VERTICES));
	assign wr_data = '{y: req.coord_y, x: req.coord_x};

	assign rd_en = (accept && is_query && (count_q >= CW'(MIN_VERTICES)))
		|| (state_q == S_FIRST)
		|| ((state_q == S_EA) && !close_q && (idx_q != count_q));
	assign rd_addr = (state_q == S_IDLE) ? '0 : idx_q[AW-1:0];

	pip_ram #(
		.WIDTH ($bits(vertex_t)),
		.DEPTH (MAX_VERTICES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// closing edge joins the last vertex back to the first
	assign bcur = close_q ? first_q : rd_data;

	assign qx = $signed(qx_q);
	assign qy = $signed(qy_q);
	assign ax = $signed(a_q.x);
	assign ay = $signed(a_q.y);
	assign bx = (state_q == S_EA) ? $signed(bcur.x) : $signed(b_q.x);
	assign by = (state_q == S_EA) ? $signed(bcur.y) : $signed(b_q.y);

	// shared multiplier: (x - xa)*(yb - ya) first, then (y - ya)*(xb - xa)
	always_comb begin
		if (state_q == S_EA) begin
			ma = DW'(qx) - DW'(ax);
			mb = DW'(by) - DW'(ay);
		end else begin
			ma = DW'(qy) - DW'(ay);
			mb = DW'(bx) - DW'(ax);
		end
	end

	assign prod = ma * mb;

	assign vhit  = (qx == ax) && (qy == ay);
	assign hhit  = (qy == ay) && (qy == by)
		&& (((qx >= ax) && (qx <= bx)) || ((qx <= ax) && (qx >= bx)));
	assign strad = ((ay <= qy) && (by > qy)) || ((ay > qy) && (by <= qy));
	assign up    = (by > ay);

	// the previous edge's products are compared in the cycle after the second one
	assign eval    = pend_q && ((state_q == S_EA) || (state_q == S_FLUSH));
	assign prod_eq = (p1_q == p2_q);
	assign crossed = up_q ? (p1_q < p2_q) : (p1_q > p2_q);

	assign rsp_load = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			ovf_q       <= 1'b0;
			close_q     <= 1'b0;
			last_q      <= 1'b0;
			hit_q       <= 1'b0;
			par_q       <= 1'b0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp.ready);
			if (eval) begin
				hit_q <= hit_q || prod_eq || ((state_q == S_EA) && (vhit || hhit));
				par_q <= par_q ^ (!prod_eq && crossed);
			end else if (state_q == S_EA) begin
				hit_q <= hit_q || vhit || hhit;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.operation)
							OP_CLEAR: begin
								count_q <= '0;
								ovf_q   <= 1'b0;
							end
							OP_APPEND: begin
								if (count_q < CW'(MAX_VERTICES)) begin
									count_q <= count_q + CW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_QUERY: begin
								if (count_q < CW'(MIN_VERTICES)) begin
									state_q <= S_OUT;
								end else begin
									idx_q   <= CW'(1);
									state_q <= S_FIRST;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FIRST: begin
					idx_q   <= idx_q + CW'(1);
					close_q <= 1'b0;
					last_q  <= 1'b0;
					hit_q   <= 1'b0;
					par_q   <= 1'b0;
					pend_q  <= 1'b0;
					state_q <= S_EA;
				end
				S_EA: begin
					pend_q <= 1'b0;
					// the edge taken with close_q set is the closing one
					last_q <= close_q;
					if (!close_q) begin
						if (idx_q == count_q) begin
							close_q <= 1'b1;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end
					state_q <= S_EB;
				end
				S_EB: begin
					pend_q  <= strad_q;
					state_q <= last_q ? S_FLUSH : S_EA;
				end
				S_FLUSH: begin
					pend_q  <= 1'b0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			qx_q  <= req.coord_x;
			qy_q  <= req.coord_y;
			few_q <= (count_q < CW'(MIN_VERTICES));
		end
		if (state_q == S_FIRST) begin
			first_q <= rd_data;
			a_q     <= rd_data;
		end
		if (state_q == S_EA) begin
			b_q     <= bcur;
			p1_q    <= prod;
			strad_q <= strad;
			up_q    <= up;
		end
		if (state_q == S_EB) begin
			p2_q <= prod;
			a_q  <= b_q;
		end
		if (rsp_load) begin
			rsp_inside_q <= !few_q && (hit_q || par_q);
			rsp_status_q <= few_q ? ST_FEW : (ovf_q ? ST_OVF : ST_OK);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.inside_res = rsp_inside_q;
	assign rsp.status     = rsp_status_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_VERTICES))
		else $error("vertex count beyond capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == CW'(MAX_VERTICES)))
		else $error("overflow flagged while store not full");

	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && (state_q != S_IDLE)) |-> (idx_q < count_q))
		else $error("vertex read beyond stored count");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result raised outside the output state");
`endif

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
	import pip_pkg::*;

	localparam logic [1:0]  OP_UNUSED    = 2'd3;
	localparam int unsigned IDLE_LIMIT   = 4000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 20;

	typedef struct {
		logic       in_poly;
		logic [1:0] status;
	} answer_t;

	logic clk;
	logic arst_n;

	pip_in_if  req_if ();
	pip_out_if rsp_if ();

	point_in_polygon_test u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// polygon as the block should hold it
	logic signed [COORD_BITS-1:0] poly_x [DEF_MAX_VERTICES];
	logic signed [COORD_BITS-1:0] poly_y [DEF_MAX_VERTICES];
	int unsigned poly_len      = 0;
	logic        poly_overflow = 1'b0;
	answer_t     pending_answers [$];

	logic        gaps_on   = 1'b1;
	logic        hold_req  = 1'b0;
	int unsigned hold_left = 0;

	int unsigned items_sent   = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned answers_seen = 0;
	int unsigned inside_seen  = 0;
	int unsigned few_seen     = 0;
	int unsigned ovf_seen     = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// crossing count with the boundary treated as inside
	function automatic logic point_inside(longint px, longint py);
		int unsigned crossings;
		int unsigned j;
		longint      xa, ya, xb, yb, lhs, rhs;
		crossings = 0;
		for (int unsigned i = 0; i < poly_len; i++) begin
			j  = (i + 1 == poly_len) ? 0 : i + 1;
			xa = poly_x[i];
			ya = poly_y[i];
			xb = poly_x[j];
			yb = poly_y[j];
			if (px == xa && py == ya)
				return 1'b1;
			if (py == ya && py == yb && ((px >= xa && px <= xb) || (px <= xa && px >= xb)))
				return 1'b1;
			if ((ya <= py && yb > py) || (ya > py && yb <= py)) begin
				lhs = (px - xa) * (yb - ya);
				rhs = (py - ya) * (xb - xa);
				if (lhs == rhs)
					return 1'b1;
				if (yb > ya) begin
					if (lhs < rhs)
						crossings++;
				end else if (lhs > rhs) begin
					crossings++;
				end
			end
		end
		return crossings[0];
	endfunction

	function automatic void apply_request(logic [1:0] op, coord_t x, coord_t y);
		answer_t ans;
		case (op)
			OP_CLEAR: begin
				poly_len      = 0;
				poly_overflow = 1'b0;
			end
			OP_APPEND: begin
				if (poly_len < DEF_MAX_VERTICES) begin
					poly_x[poly_len] = x;
					poly_y[poly_len] = y;
					poly_len++;
				end else begin
					poly_overflow = 1'b1;
				end
			end
			OP_QUERY: begin
				if (poly_len < MIN_VERTICES) begin
					ans.in_poly = 1'b0;
					ans.status  = ST_FEW;
				end else begin
					ans.in_poly = point_inside(signed'(x), signed'(y));
					ans.status  = poly_overflow ? ST_OVF : ST_OK;
				end
				pending_answers.push_back(ans);
			end
			default: ;
		endcase
	endfunction

	// prediction at each request transfer, checking at each result transfer
	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (pending_answers.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result: inside=%0b status=%0d",
							rsp_if.inside_res, rsp_if.status);
				end else begin
					want = pending_answers.pop_front();
					answers_seen++;
					if (want.in_poly)
						inside_seen++;
					if (want.status == ST_FEW)
						few_seen++;
					if (want.status == ST_OVF)
						ovf_seen++;
					if (rsp_if.inside_res !== want.in_poly || rsp_if.status !== want.status) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("answer %0d wrong: expected inside=%0b status=%0d, got inside=%0b status=%0d",
								answers_seen, want.in_poly, want.status,
								rsp_if.inside_res, rsp_if.status);
					end
				end
			end
			if (req_if.valid && req_if.ready)
				apply_request(req_if.operation, req_if.coord_x, req_if.coord_y);
		end
	end

	// result side: random stalls, or a long hold-off when asked
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= !gaps_on || $urandom_range(99) >= 32;
			end
		end
	end

	initial begin
		int unsigned idle_run;
		idle_run = 0;
		while (idle_run < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("timeout: no transfer for %0d cycles, %0d answers outstanding",
			IDLE_LIMIT, pending_answers.size());
		$display("tb_top NOT OK");
		$finish;
	end

	// valid stays high after a transfer; the next call either keeps it or drops it for a gap
	task automatic send_item(input logic [1:0] op, input int x, input int y);
		while (gaps_on && $urandom_range(99) < 32) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.operation <= op;
		req_if.coord_x   <= x[COORD_BITS-1:0];
		req_if.coord_y   <= y[COORD_BITS-1:0];
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	function automatic int rand_coord(int unsigned span);
		if (span == 0)
			return int'($urandom_range(65535)) - 32768;
		return int'($urandom_range(2 * span)) - int'(span);
	endfunction

	task automatic test_short_polygon();
		send_item(OP_QUERY, 0, 0);
		send_item(OP_APPEND, 1, 1);
		send_item(OP_APPEND, -1, 1);
		send_item(OP_UNUSED, 5, 5);
		send_item(OP_QUERY, 0, 1);
	endtask

	task automatic test_boundary_cases();
		send_item(OP_CLEAR, 0, 0);
		send_item(OP_APPEND, 0, 0);
		send_item(OP_APPEND, 20, 0);
		send_item(OP_APPEND, 10, 20);
		send_item(OP_QUERY, 10, 5);
		send_item(OP_QUERY, 30, 5);
		send_item(OP_QUERY, 20, 0);
		send_item(OP_QUERY, 5, 0);
		send_item(OP_QUERY, 5, 10);
		// closing vertex repeated: zero-length edge
		send_item(OP_APPEND, 0, 0);
		send_item(OP_QUERY, 10, 5);
		send_item(OP_QUERY, -1, 10);
	endtask

	task automatic test_extremes();
		send_item(OP_CLEAR, 0, 0);
		send_item(OP_APPEND, -32768, -32768);
		send_item(OP_APPEND, 32767, 32767);
		send_item(OP_APPEND, -32768, 32767);
		send_item(OP_QUERY, 0, 0);
		send_item(OP_QUERY, 1, 0);
		send_item(OP_QUERY, -32768, 32767);
		send_item(OP_QUERY, 32767, -32768);
	endtask

	task automatic test_overflow();
		send_item(OP_CLEAR, 0, 0);
		repeat (DEF_MAX_VERTICES + 3)
			send_item(OP_APPEND, rand_coord(1000), rand_coord(1000));
		send_item(OP_QUERY, rand_coord(1000), rand_coord(1000));
		send_item(OP_QUERY, 0, 0);
		send_item(OP_CLEAR, 0, 0);
		send_item(OP_QUERY, 0, 0);
		send_item(OP_APPEND, -50, -50);
		send_item(OP_APPEND, 50, -50);
		send_item(OP_APPEND, 0, 50);
		send_item(OP_QUERY, 0, 0);
	endtask

	task automatic run_random_polygons(input int unsigned n_items);
		int unsigned stop_at, n_vert, span, roll, k, j;
		int          gx [$];
		int          gy [$];
		int          qx, qy;
		logic [1:0]  op;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			roll = $urandom_range(99);
			span = roll < 60 ? 6 : roll < 85 ? 1000 : 0;
			if ($urandom_range(99) < 85) begin
				// mostly a fresh polygon, sometimes the old one grows
				if ($urandom_range(9) != 0) begin
					send_item(OP_CLEAR, rand_coord(0), rand_coord(0));
					gx.delete();
					gy.delete();
				end
				roll   = $urandom_range(99);
				n_vert = roll < 8 ? $urandom_range(2) : roll < 98 ? $urandom_range(3, 10)
					: $urandom_range(40, 80);
				repeat (n_vert) begin
					qx = rand_coord(span);
					qy = rand_coord(span);
					send_item(OP_APPEND, qx, qy);
					if (gx.size() < DEF_MAX_VERTICES) begin
						gx.push_back(qx);
						gy.push_back(qy);
					end
				end
				repeat ($urandom_range(1, 6)) begin
					roll = $urandom_range(99);
					if (roll < 30 && gx.size() > 0) begin
						k  = $urandom_range(gx.size() - 1);
						qx = gx[k];
						qy = gy[k];
					end else if (roll < 50 && gx.size() > 1) begin
						// edge midpoint, exact on the edge when the sums are even
						k  = $urandom_range(gx.size() - 1);
						j  = (k + 1) % gx.size();
						qx = (gx[k] + gx[j]) >>> 1;
						qy = (gy[k] + gy[j]) >>> 1;
					end else begin
						qx = rand_coord(span);
						qy = rand_coord(span);
					end
					send_item(OP_QUERY, qx, qy);
				end
			end else begin
				op = 2'($urandom_range(3));
				qx = rand_coord(0);
				qy = rand_coord(0);
				send_item(op, qx, qy);
				if (op == OP_CLEAR) begin
					gx.delete();
					gy.delete();
				end else if (op == OP_APPEND && gx.size() < DEF_MAX_VERTICES) begin
					gx.push_back(qx);
					gy.push_back(qy);
				end
			end
		end
	endtask

	task automatic test_back_pressure();
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		send_item(OP_CLEAR, 0, 0);
		send_item(OP_APPEND, -400, -300);
		send_item(OP_APPEND, 500, -200);
		send_item(OP_APPEND, 600, 400);
		send_item(OP_APPEND, 0, 700);
		send_item(OP_APPEND, -500, 300);
		repeat (12)
			send_item(OP_QUERY, rand_coord(800), rand_coord(800));
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		req_if.valid     <= 1'b0;
		req_if.operation <= OP_CLEAR;
		req_if.coord_x   <= '0;
		req_if.coord_y   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_short_polygon();
		test_boundary_cases();
		test_extremes();
		test_overflow();
		run_random_polygons(300);
		gaps_on = 1'b0;
		run_random_polygons(120);
		gaps_on = 1'b1;
		test_back_pressure();
		run_random_polygons(40);

		req_if.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests driven; %0d query answers compared", items_sent, answers_seen);
		$display("answers: %0d inside, %0d short polygon, %0d after dropped vertices, %0d mismatches",
			inside_seen, few_seen, ovf_seen, mismatch_cnt);
		if (mismatch_cnt == 0 && pending_answers.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
